### rtl/core/kwe_pkg.sv
// Kaiser window evaluator package: shared widths and fixed-point constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package kwe_pkg;
    localparam int MAX_TERMS_DEF = 128;
    localparam int POS_W         = 16;            // Q2.14 position
    localparam int BETA_W        = 16;            // Q4.12 beta
    localparam int VAL_W         = 16;            // Q1.15 weight
    localparam int DIV_W         = 32;            // series divider dividend width
    localparam int MUL_A_W       = 34;
    localparam int MUL_B_W       = 32;
    localparam int MUL_P_W       = MUL_A_W + MUL_B_W;
    localparam logic [15:0] MAG_ONE   = 16'd16384; // 1.0 in Q2.14
    localparam logic [15:0] VAL_ONE   = 16'd32768; // 1.0 in Q1.15
    localparam logic [63:0] ONE_Q44   = 64'h0000_1000_0000_0000;
    localparam int          QUO_BITS  = 15;
endpackage : kwe_pkg
`default_nettype wire

### rtl/core/kaiser_window_evaluator_unit.sv
// Kaiser window evaluator top level: sequencer, shared multiplier, sqrt and quotient steps.
// Depends on kwe_pkg and kwe_div.
`timescale 1ns / 1ps
`default_nettype none
// Takes one signed Q2.14 position per start pulse (accepted when busy is low) and returns
// w = I0(beta*sqrt(1-p^2)) / I0(beta) in unsigned Q1.15, saturated at 1.0, as one word on
// window_value marked by a one-cycle done strobe; the receiver cannot stall, so the word
// must be taken in that cycle. Beta (Q4.12) is written through shape_beta_we; the user
// must write it only while idle, which the block itself does not enforce. Positions
// outside -1..+1 answer 0 in the cycle right after start is taken. Otherwise, the item
// runs the square, the 17-step shift/subtract sqrt and the beta multiply, then two
// Bessel series (numerator, then denominator) of 1 to MAX_TERMS-1 terms each, each
// stopping early once a term is negligible, then 15 quotient steps and the done
// strobe; a saturating ratio skips the quotient steps. Each term is one launch of the
// bit-serial divider (x/2k) and five steps on the one shared 34x32 multiplier and
// adders (square, two partial products, combine, accumulate). Betas of 5 to 9 need
// some 15 to 25 terms per series.
module kaiser_window_evaluator_unit #(
    parameter int MAX_TERMS = kwe_pkg::MAX_TERMS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic signed [kwe_pkg::POS_W-1:0] window_position,
    input  wire logic                       shape_beta_we,
    input  wire logic [kwe_pkg::BETA_W-1:0] shape_beta,
    output logic                            done,
    output logic [kwe_pkg::VAL_W-1:0]       window_value
);
    import kwe_pkg::*;

    localparam int K_W = $clog2(MAX_TERMS);
    localparam int Q_W = $clog2(QUO_BITS);

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_MAG  = 12'b0000_0000_0010,
        S_SQRT = 12'b0000_0000_0100,
        S_XM   = 12'b0000_0000_1000,
        S_DGO  = 12'b0000_0001_0000,
        S_DIV  = 12'b0000_0010_0000,
        S_SQ   = 12'b0000_0100_0000,
        S_ML   = 12'b0000_1000_0000,
        S_MH   = 12'b0001_0000_0000,
        S_ACC  = 12'b0010_0000_0000,
        S_SUM  = 12'b0100_0000_0000,
        S_QUO  = 12'b1000_0000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [BETA_W-1:0]  beta_reg;
    logic [15:0]        mag_reg, mag_next;
    logic [32:0]        v_reg, v_next;        // sqrt radicand remainder
    logic [33:0]        res_reg, res_next;    // sqrt partial root
    logic [32:0]        bit_reg, bit_next;
    logic [31:0]        x_reg, x_next;        // Bessel argument, Q4.28
    logic               den_ph_reg, den_ph_next;
    logic [K_W-1:0]     k_reg, k_next;
    logic [33:0]        f2_reg, f2_next;
    logic [63:0]        term_reg, term_next;
    logic [63:0]        sum_reg, sum_next;
    logic [65:0]        acc_reg, acc_next;
    logic [65:0]        hi_reg, hi_next;
    logic [63:0]        num_reg, num_next;
    logic [63:0]        rem_reg, rem_next;
    logic [QUO_BITS-1:0] q_reg, q_next;
    logic [Q_W-1:0]     qc_reg, qc_next;
    logic               done_reg, done_next;
    logic [VAL_W-1:0]   val_reg, val_next;

    // shared multiplier
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;

    logic               div_done;
    logic [DIV_W-1:0]   div_q;

    logic [15:0]        pos_mag;
    logic [28:0]        span;
    logic [33:0]        sq_trial;
    logic [97:0]        full;
    logic [64:0]        sum_add;
    logic [63:0]        quo_diff;

    assign pos_mag = window_position[POS_W-1] ? 16'(-window_position) : 16'(window_position);

    always_comb
    begin
        unique case (state_reg)
            S_MAG:   begin mul_a = MUL_A_W'(mag_reg);       mul_b = MUL_B_W'(mag_reg);  end
            S_XM:    begin mul_a = MUL_A_W'(res_reg[16:0]); mul_b = MUL_B_W'(beta_reg); end
            S_SQ:    begin mul_a = MUL_A_W'(div_q);         mul_b = div_q;              end
            S_ML:    begin mul_a = f2_reg;                  mul_b = term_reg[31:0];     end
            S_MH:    begin mul_a = f2_reg;                  mul_b = term_reg[63:32];    end
            default: begin mul_a = '0;                      mul_b = '0;                 end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    assign span     = 29'h1000_0000 - mul_p[28:0];
    assign sq_trial = res_reg + {1'b0, bit_reg};
    assign full     = {hi_reg, 32'b0} + {32'b0, acc_reg};
    assign sum_add  = {1'b0, sum_reg} + {1'b0, term_reg};
    assign quo_diff = sum_reg - rem_reg;   // sum_reg holds den during the quotient

    kwe_div #(
        .K_W (K_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_DGO),
        .dividend ({1'b0, x_reg[31:1]}),
        .divisor  (k_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next  = state_reg;
        mag_next    = mag_reg;
        v_next      = v_reg;
        res_next    = res_reg;
        bit_next    = bit_reg;
        x_next      = x_reg;
        den_ph_next = den_ph_reg;
        k_next      = k_reg;
        f2_next     = f2_reg;
        term_next   = term_reg;
        sum_next    = sum_reg;
        acc_next    = acc_reg;
        hi_next     = hi_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        qc_next     = qc_reg;
        done_next   = 1'b0;
        val_next    = val_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (pos_mag > MAG_ONE)
                    begin
                        val_next  = '0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        mag_next   = pos_mag;
                        state_next = S_MAG;
                    end
                end
            end
            S_MAG:
            begin
                v_next     = {span, 4'b0};
                res_next   = '0;
                bit_next   = 33'h1_0000_0000;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if ({1'b0, v_reg} >= sq_trial)
                begin
                    v_next   = v_reg - sq_trial[32:0];
                    res_next = (res_reg >> 1) + {1'b0, bit_reg};
                end
                else
                    res_next = res_reg >> 1;
                bit_next = bit_reg >> 2;
                if (bit_reg == 33'd1)
                    state_next = S_XM;
            end
            S_XM:
            begin
                x_next      = mul_p[31:0];
                den_ph_next = 1'b0;
                k_next      = K_W'(1);
                term_next   = ONE_Q44;
                sum_next    = ONE_Q44;
                state_next  = S_DGO;
            end
            S_DGO:
                state_next = S_DIV;
            S_DIV:
                if (div_done)
                    state_next = S_SQ;
            S_SQ:
            begin
                f2_next    = mul_p[61:28];
                state_next = S_ML;
            end
            S_ML:
            begin
                acc_next   = mul_p;
                state_next = S_MH;
            end
            S_MH:
            begin
                hi_next    = mul_p;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                term_next  = (full[97:92] != '0) ? '1 : full[91:28];
                state_next = S_SUM;
            end
            S_SUM:
            begin
                sum_next = sum_add[64] ? '1 : sum_add[63:0];
                if (term_reg == '0 || term_reg < {59'b0, sum_next[63:59]}
                    || k_reg == K_W'(MAX_TERMS - 1))
                begin
                    if (!den_ph_reg)
                    begin
                        num_next    = sum_next;
                        x_next      = {beta_reg, 16'b0};
                        den_ph_next = 1'b1;
                        k_next      = K_W'(1);
                        term_next   = ONE_Q44;
                        sum_next    = ONE_Q44;
                        state_next  = S_DGO;
                    end
                    else if (num_reg >= sum_next)
                    begin
                        val_next   = VAL_ONE;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rem_next   = num_reg;
                        q_next     = '0;
                        qc_next    = '0;
                        state_next = S_QUO;
                    end
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_DGO;
                end
            end
            S_QUO:
            begin
                // one quotient bit per cycle, num < den keeps rem below den
                if (rem_reg >= quo_diff)
                begin
                    rem_next = rem_reg - quo_diff;
                    q_next   = {q_reg[QUO_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_reg << 1;
                    q_next   = {q_reg[QUO_BITS-2:0], 1'b0};
                end
                qc_next = qc_reg + 1'b1;
                if (qc_reg == Q_W'(QUO_BITS - 1))
                begin
                    val_next   = VAL_W'(q_next);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            beta_reg   <= '0;
            done_reg   <= 1'b0;
            den_ph_reg <= 1'b0;
            k_reg      <= '0;
            qc_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            den_ph_reg <= den_ph_next;
            k_reg      <= k_next;
            qc_reg     <= qc_next;
            if (shape_beta_we)
                beta_reg <= shape_beta;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        v_reg    <= v_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        x_reg    <= x_next;
        f2_reg   <= f2_next;
        term_reg <= term_next;
        sum_reg  <= sum_next;
        acc_reg  <= acc_next;
        hi_reg   <= hi_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        val_reg  <= val_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign window_value = val_reg;
endmodule : kaiser_window_evaluator_unit
`default_nettype wire

### rtl/core/kwe_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on kwe_pkg (DIV_W).
`timescale 1ns / 1ps
`default_nettype none
module kwe_div #(
    parameter int K_W = 7
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [kwe_pkg::DIV_W-1:0] dividend,
    input  wire logic [K_W-1:0]           divisor,
    output logic                          done,
    output logic [kwe_pkg::DIV_W-1:0]     quotient
);
    import kwe_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic [DIV_W-1:0] shq_reg, shq_next;
    logic [K_W-1:0]   rem_reg, rem_next;
    logic [K_W-1:0]   dsr_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [K_W:0]     trial;
    logic [K_W:0]     diff;

    assign trial = {rem_reg, shq_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        shq_next  = shq_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            shq_next = dividend;
            rem_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = diff[K_W-1:0];
                shq_next = {shq_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[K_W-1:0];
                shq_next = {shq_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shq_reg <= shq_next;
        rem_reg <= rem_next;
        if (start)
            dsr_reg <= divisor;
    end

    assign done     = done_reg;
    assign quotient = shq_reg;
endmodule : kwe_div
`default_nettype wire

### sim/testbench.sv
// Testbench for kaiser_window_evaluator_unit: directed and random positions over several betas.
// Depends on kwe_pkg and the evaluator RTL; a scoreboard class predicts each weight.
`timescale 1ns / 1ps

// Holds the beta setting, predicts the Q1.15 weight of each accepted position
// and compares the done words against them in order.
class window_scoreboard;
    logic [15:0] beta;
    logic [15:0] weight_q[$];
    int          errors;

    function new();
        beta   = 16'd0;
        errors = 0;
    endfunction

    // floor(a*b / 2^28), saturating
    function logic [63:0] mul_q28(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        if (p[127:92] != 0)
            return '1;
        return p[91:28];
    endfunction

    function logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bits;
        res  = 0;
        bits = 64'd1 << 32;
        while (bits > v)
            bits = bits >> 2;
        while (bits != 0)
        begin
            if (v >= res + bits)
            begin
                v   = v - (res + bits);
                res = (res >> 1) + bits;
            end
            else
                res = res >> 1;
            bits = bits >> 2;
        end
        return res;
    endfunction

    // I0(x), x in Q4.28, result in Q20.44
    function logic [63:0] bessel_i0(logic [63:0] x);
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] f;
        logic [63:0] f2;
        sum  = kwe_pkg::ONE_Q44;
        term = kwe_pkg::ONE_Q44;
        for (int k = 1; k < kwe_pkg::MAX_TERMS_DEF; k++)
        begin
            f    = x / (2 * k);
            f2   = (f * f) >> 28;
            term = mul_q28(term, f2);
            sum  = (sum > ~term) ? '1 : sum + term;
            if (term == 0 || term < (sum >> 59))
                break;
        end
        return sum;
    endfunction

    function logic [15:0] weight_of(logic signed [15:0] pos);
        logic [63:0] mag;
        logic [63:0] root;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] rem;
        logic [15:0] q;
        mag = pos[15] ? 64'h10000 - {48'd0, pos} : {48'd0, pos};
        if (mag > kwe_pkg::MAG_ONE)
            return 16'd0;
        root = floor_sqrt(((64'd1 << 28) - mag * mag) << 4);
        num  = bessel_i0({48'd0, beta} * root);
        den  = bessel_i0({48'd0, beta} << 16);
        if (num >= den)
            return kwe_pkg::VAL_ONE;
        rem = num;
        q   = 0;
        for (int i = 0; i < kwe_pkg::QUO_BITS; i++)
        begin
            q = q << 1;
            if (rem >= den - rem)
            begin
                rem  = rem - (den - rem);
                q[0] = 1'b1;
            end
            else
                rem = rem << 1;
        end
        return q;
    endfunction

    function void note_position(logic signed [15:0] pos);
        weight_q.push_back(weight_of(pos));
    endfunction

    function void check_weight(logic [15:0] got);
        logic [15:0] want;
        if (weight_q.size() == 0)
        begin
            $display("%0t: unexpected word window_value expected none actual %0d", $time, got);
            errors++;
            return;
        end
        want = weight_q.pop_front();
        if (got !== want)
        begin
            $display("%0t: window_value mismatch expected %0d actual %0d", $time, want, got);
            errors++;
        end
    endfunction
endclass

module testbench;
    import kwe_pkg::*;

    localparam int WATCHDOG_LIMIT = 60000;   // well above the longest item

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic signed [POS_W-1:0]  window_position;
    logic                     shape_beta_we;
    logic [BETA_W-1:0]        shape_beta;
    logic                     done;
    logic [VAL_W-1:0]         window_value;

    window_scoreboard weights;
    int               idle_pct;
    int               stall_cycles;

    kaiser_window_evaluator_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .window_position (window_position),
        .shape_beta_we   (shape_beta_we),
        .shape_beta      (shape_beta),
        .done            (done),
        .window_value    (window_value)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // results cannot be held off: every done word is checked on the edge it is taken
    always @(posedge clk)
    begin
        if (rst_n && done)
            weights.check_weight(window_value);
    end

    // watchdog: cycles with no accepted position and no done word
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // holds start high until the word is accepted; start stays high on return
    task automatic send_position(logic signed [15:0] pos);
        @(negedge clk);
        start           <= 1'b1;
        window_position <= pos;
        do
            @(posedge clk);
        while (busy);
        weights.note_position(pos);
    endtask

    task automatic sender_gap();
        if ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(6)) @(negedge clk);
        end
    endtask

    // waits until every expected word is back and the block is idle
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        do
            @(posedge clk);
        while (weights.weight_q.size() != 0 || busy);
    endtask

    task automatic write_beta(logic [15:0] value);
        @(negedge clk);
        shape_beta_we <= 1'b1;
        shape_beta    <= value;
        @(negedge clk);
        shape_beta_we <= 1'b0;
        weights.beta = value;
    endtask

    function automatic logic signed [15:0] random_position();
        // mostly inside the window, where the series do the work
        if ($urandom_range(99) < 80)
            return $signed(16'($urandom_range(32768))) - 16'sd16384;
        return 16'($urandom);
    endfunction

    logic [15:0] beta_plan[7];
    logic signed [15:0] edge_pos[$];

    initial
    begin
        weights         = new();
        rst_n           = 1'b0;
        start           = 1'b0;
        window_position = '0;
        shape_beta_we   = 1'b0;
        shape_beta      = '0;
        stall_cycles    = 0;
        idle_pct        = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // beta zero (reset value, written anyway), top of range, small, typical ones
        beta_plan = '{16'd0, 16'hFFFF, 16'd1, 16'd20480, 16'd35226, 16'($urandom), 16'd4096};
        edge_pos  = '{16'sd0, 16'sd16384, -16'sd16384, 16'sd16385, -16'sd16385, 16'sd32767,
                      -16'sd32768, 16'sd1, -16'sd1, 16'sd16383, -16'sd16383, 16'sd8192,
                      -16'sd8192, 16'sh5555, 16'shAAAA, 16'sh2AAA, -16'sh2AAA};

        for (int ph = 0; ph < 7; ph++)
        begin
            write_beta(beta_plan[ph]);
            // sender idle mix: none, 61%, 19%, cycled over phases
            case (ph % 3)
                0: idle_pct = 0;
                1: idle_pct = 61;
                default: idle_pct = 19;
            endcase
            if (ph < 2)
                foreach (edge_pos[i])
                begin
                    send_position(edge_pos[i]);
                    sender_gap();
                end
            for (int n = 0; n < 245; n++)
            begin
                send_position(random_position());
                if (n == 120)
                    drain();
                else
                    sender_gap();
            end
            drain();
        end

        repeat (50) @(posedge clk);
        if (weights.errors == 0 && weights.weight_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

### filelist.f
rtl/core/kwe_pkg.sv
rtl/core/kwe_div.sv
rtl/core/kaiser_window_evaluator_unit.sv
sim/testbench.sv
